/* hdl/ias_pkg.sv */
// ----------------------------------------------------------------------------
// ias_pkg
// Shared types and constants for the index argsort cell chain.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    // contents of one sorting cell
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [IDX_W-1:0]        idx;
    } t_cell_data;

    // chain control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctl;

    typedef enum logic [0:0] {
        S_LOAD,
        S_DRAIN
    } t_state;

endpackage

/* hdl/ias_cell.sv */
// ----------------------------------------------------------------------------
// ias_cell
// One sorting cell: holds a key and its arrival index; on load takes the new
// key or the previous cell's entry, and shifts toward the head during drain.
// ----------------------------------------------------------------------------
module ias_cell
    import ias_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_chain_ctl              i_ctl,
    input  logic signed [KEY_W-1:0] i_new_key,
    input  logic [IDX_W-1:0]        i_new_idx,
    input  logic                    i_prev_take,
    input  t_cell_data              i_prev,
    input  t_cell_data              i_next,
    output logic                    o_take,
    output t_cell_data              o_data
);

    t_cell_data r_data;
    t_cell_data n_data;

    // strict compare keeps equal keys in arrival order
    assign o_take = !r_data.valid || ($signed(i_new_key) < $signed(r_data.key));
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            if (i_prev_take) begin
                n_data = i_prev;
            end else if (o_take) begin
                n_data.valid = 1'b1;
                n_data.key   = i_new_key;
                n_data.idx   = i_new_idx;
            end
        end else if (i_ctl.shift) begin
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data.valid <= n_data.valid;
        end
        r_data.key <= n_data.key;
        r_data.idx <= n_data.idx;
    end

endmodule

/* hdl/ias_chain.sv */
// ----------------------------------------------------------------------------
// ias_chain
// Row of sorting cells kept in ascending key order, empty cells at the tail.
// ----------------------------------------------------------------------------
module ias_chain
    import ias_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_chain_ctl              i_ctl,
    input  logic signed [KEY_W-1:0] i_new_key,
    input  logic [IDX_W-1:0]        i_new_idx,
    output t_cell_data              o_head,
    output logic                    o_second_valid
);

    // w_cell[i+1] is cell i; both ends read as empty
    t_cell_data w_cell [0:MAX_KEYS+1];
    logic       w_take [0:MAX_KEYS];

    assign w_cell[0]          = '0;
    assign w_cell[MAX_KEYS+1] = '0;
    assign w_take[0]          = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_KEYS; g++) begin : g_cell
            ias_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (i_ctl),
                .i_new_key   (i_new_key),
                .i_new_idx   (i_new_idx),
                .i_prev_take (w_take[g]),
                .i_prev      (w_cell[g]),
                .i_next      (w_cell[g+2]),
                .o_take      (w_take[g+1]),
                .o_data      (w_cell[g+1])
            );
        end
    endgenerate

    assign o_head         = w_cell[1];
    assign o_second_valid = w_cell[2].valid;

endmodule

/* hdl/index_argsort.sv */
// ----------------------------------------------------------------------------
// index_argsort
// Stable ascending argsort of signed Q16.16 keys in an insertion cell chain.
// Load: one key per cycle, inserted into the chain in the cycle it arrives;
// keys past MAX_KEYS are dropped. First result in the cycle after the last
// key, then one result per cycle while the receiver is ready.
// Synchronous active-low reset empties the chain and returns to loading.
// ----------------------------------------------------------------------------
module index_argsort
    import ias_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic                    i_last,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [IDX_W-1:0]        o_index,
    output logic signed [KEY_W-1:0] o_sorted_key,
    output logic                    o_last_res
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_chain_ctl       w_ctl;
    t_cell_data       w_head;
    logic             w_second_valid;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_room;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign w_room    = r_count < CNT_W'(MAX_KEYS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_out_acc && o_last_res) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        w_ctl     = '0;
        unique case (r_state)
            S_LOAD: begin
                o_ready   = 1'b1;
                w_ctl.load = w_in_acc && w_room;
            end
            S_DRAIN: begin
                o_valid     = w_head.valid;
                w_ctl.shift = w_out_acc;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.load) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_out_acc && o_last_res) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    ias_chain u_chain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_new_key      (i_key),
        .i_new_idx      (r_count[IDX_W-1:0]),
        .o_head         (w_head),
        .o_second_valid (w_second_valid)
    );

    assign o_index      = w_head.idx;
    assign o_sorted_key = w_head.key;
    // head is the final word once nothing stands behind it
    assign o_last_res   = !w_second_valid;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input and output phases overlap");

    a_drain_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_last) |=> o_valid)
        else $error("no result after last key");

    a_load_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_res) |=> (o_ready && !o_valid && r_count == '0))
        else $error("chain not empty after final word");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEYS))
        else $error("key count beyond bound");

endmodule

/* tb/index_argsort_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// index_argsort_chk
// Watches both channels of index_argsort, keeps its own copy of the key set,
// ranks each completed set with a stable ascending sort and compares every
// output word with the oldest ranked entry still waiting.
// ----------------------------------------------------------------------------
module index_argsort_chk
    import ias_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic                    i_last,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [IDX_W-1:0]        i_index,
    input  logic signed [KEY_W-1:0] i_sorted_key,
    input  logic                    i_last_res,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [KEY_W-1:0] sorted_key;
        logic                    last_res;
    } t_ranked;

    logic signed [KEY_W-1:0] held_keys [MAX_KEYS];
    int                      held_count = 0;
    t_ranked                 ranked_q [$];

    // stable insertion sort of arrival positions, then queue one word per rank
    function automatic void rank_held_set();
        int      order [MAX_KEYS];
        int      pos;
        t_ranked word;
        for (int i = 0; i < held_count; i++) begin
            pos = i;
            while (pos > 0 && held_keys[i] < held_keys[order[pos-1]]) begin
                order[pos] = order[pos-1];
                pos--;
            end
            order[pos] = i;
        end
        for (int i = 0; i < held_count; i++) begin
            word.index      = order[i][IDX_W-1:0];
            word.sorted_key = held_keys[order[i]];
            word.last_res   = (i == held_count - 1);
            ranked_q        = {ranked_q, word};
        end
    endfunction

    always @(posedge i_clk) begin
        t_ranked want;
        if (i_rst_n) begin
            // output side first, so a word that races its own set is caught
            if (i_out_valid && i_out_ready) begin
                if (ranked_q.size() == 0) begin
                    $error("unexpected word: index %0d key %0d last %0d",
                           i_index, i_sorted_key, i_last_res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = ranked_q.pop_front();
                    if (i_index !== want.index || i_sorted_key !== want.sorted_key ||
                        i_last_res !== want.last_res) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (i_index !== want.index)
                        $error("index: expected %0d, got %0d", want.index, i_index);
                    if (i_sorted_key !== want.sorted_key)
                        $error("sorted_key: expected %0d, got %0d",
                               want.sorted_key, i_sorted_key);
                    if (i_last_res !== want.last_res)
                        $error("last_res: expected %0d, got %0d",
                               want.last_res, i_last_res);
                end
            end
            if (i_in_valid && i_in_ready) begin
                // keys beyond the bound are dropped, the closing key too
                if (held_count < MAX_KEYS) begin
                    held_keys[held_count] = i_key;
                    held_count++;
                end
                if (i_last) begin
                    rank_held_set();
                    held_count = 0;
                end
            end
        end else begin
            o_fail_count <= 0;
        end
        o_pending <= ranked_q.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for index_argsort: directed sets around the key
// extremes and ties, then random sets of mixed shape including full and
// overlong sets, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_top;
    import ias_pkg::*;

    typedef enum int {
        MIX_RANDOM,
        MIX_TIES,
        MIX_RISING,
        MIX_FALLING,
        MIX_FLAT
    } t_key_mix;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } t_rx_mode;

    localparam int RANDOM_ITEMS = 360;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic signed [KEY_W-1:0] i_key   = '0;
    logic                    i_last  = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [IDX_W-1:0]        o_index;
    logic signed [KEY_W-1:0] o_sorted_key;
    logic                    o_last_res;

    int fail_count;
    int pending;
    int burst_left = 0;
    int random_sent = 0;

    always #4 i_clk = ~i_clk;

    index_argsort i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_key        (i_key),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_index      (o_index),
        .o_sorted_key (o_sorted_key),
        .o_last_res   (o_last_res)
    );

    index_argsort_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_key        (i_key),
        .i_last       (i_last),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_index      (o_index),
        .i_sorted_key (o_sorted_key),
        .i_last_res   (o_last_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // one key word, held until taken; gaps fall between bursts
    task automatic send_key(input logic signed [KEY_W-1:0] key, input logic last);
        i_valid <= 1'b1;
        i_key   <= key;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_set(input int count, input t_key_mix mix);
        logic signed [KEY_W-1:0] tie_pool [4];
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] step;
        for (int p = 0; p < 4; p++) tie_pool[p] = $urandom();
        if ($urandom_range(0, 1)) tie_pool[0] = 32'sh8000_0000;
        if ($urandom_range(0, 1)) tie_pool[3] = 32'sh7fff_ffff;
        key  = $urandom();
        step = $urandom_range(0, 1) ? 32'sd1 : 32'sh0001_0000;
        for (int i = 0; i < count; i++) begin
            case (mix)
                MIX_RANDOM:  key = $urandom();
                MIX_TIES:    key = tie_pool[$urandom_range(0, 3)];
                MIX_RISING:  if (i != 0) key = key + step;
                MIX_FALLING: if (i != 0) key = key - step;
                default:     ;
            endcase
            send_key(key, i == count - 1);
        end
    endtask

    // output side stall patterns
    t_rx_mode rx_mode    = RX_OPEN;
    int       mode_left  = 0;
    int       stall_left = 0;
    int       rx_period  = 3;
    int       rx_phase   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
                rx_period = $urandom_range(2, 7);
            end else begin
                mode_left--;
            end
            rx_phase = (rx_phase + 1) % rx_period;
            case (rx_mode)
                RX_OPEN:     i_ready <= 1'b1;
                RX_RANDOM:   i_ready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: i_ready <= (rx_phase != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        i_ready <= 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(4, 20);
                        i_ready <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin
        int       set_no;
        int       count;
        t_key_mix mix;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-key sets at the extremes
        send_key(32'sd0, 1'b1);
        send_key(32'sh7fff_ffff, 1'b1);
        send_key(32'sh8000_0000, 1'b1);
        // mixed extremes, with a tie on the most negative key
        send_key(32'sh7fff_ffff, 1'b0);
        send_key(32'sh8000_0000, 1'b0);
        send_key(32'sd0, 1'b0);
        send_key(-32'sd1, 1'b0);
        send_key(32'sd1, 1'b0);
        send_key(32'sh0001_0000, 1'b0);
        send_key(32'shffff_0000, 1'b0);
        send_key(32'sh8000_0000, 1'b1);
        // interleaved ties must keep arrival order
        send_key(32'sd5, 1'b0);
        send_key(-32'sd3, 1'b0);
        send_key(32'sd5, 1'b0);
        send_key(-32'sd3, 1'b0);
        send_key(32'sd5, 1'b1);
        // strictly falling set
        send_key(32'sh0003_0000, 1'b0);
        send_key(32'sh0002_8000, 1'b0);
        send_key(-32'sh0000_8000, 1'b0);
        send_key(-32'sh0004_0000, 1'b1);

        set_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (set_no == 2 || set_no == 30) begin
                count = MAX_KEYS;
            end else if (set_no == 5 || set_no == 41) begin
                count = $urandom_range(MAX_KEYS + 1, MAX_KEYS + 6);
            end else if ($urandom_range(0, 9) < 8) begin
                count = $urandom_range(1, 8);
            end else begin
                count = $urandom_range(9, 24);
            end
            mix = t_key_mix'($urandom_range(0, 4));
            send_set(count, mix);
            random_sent += count;
            set_no++;
        end
        i_valid <= 1'b0;

        // let the checker's pending count catch up with the final set
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
hdl/ias_pkg.sv
hdl/ias_cell.sv
hdl/ias_chain.sv
hdl/index_argsort.sv
tb/index_argsort_chk.sv
tb/tb_top.sv
